### hw/rtl/nucleotide_key_hash_set_core_defines.svh
// Assertion macros for the nucleotide key hash set core.
// Included by the top level; no other dependencies.
`ifndef NUCLEOTIDE_KEY_HASH_SET_CORE_DEFINES_SVH
`define NUCLEOTIDE_KEY_HASH_SET_CORE_DEFINES_SVH
`define NKH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NKH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### hw/rtl/nkh_pkg.sv
// Package for the nucleotide key hash set: payload types, constants, back-part states, symbol digits.
// No dependencies.
`timescale 1ns / 1ps
package nkh_pkg;
	localparam int unsigned TABLE_SLOTS_DEF = 1024;
	localparam logic [63:0] SEED_RESET = 64'd114514;
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MUL2 = 64'h94d049bb133111eb;
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_FIND = 1'b1;

	typedef struct packed {
		logic action;
		logic [7:0] symbol;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic table_full;
	} out_item_t;

	typedef struct packed {
		logic action;
		logic [63:0] key;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MIX, ST_PROBE, ST_CHECK, ST_DONE
	} back_state_t;

	function automatic logic [2:0] sym_digit(input logic [7:0] s);
		logic [2:0] d;
		case (s)
			8'h41: d = 3'd4;
			8'h43: d = 3'd3;
			8'h47: d = 3'd2;
			default: d = 3'd1;
		endcase
		return d;
	endfunction
endpackage

### hw/rtl/nkh_front.sv
// Front part: folds characters into the key and emits a command on the last one.
// Depends on nkh_pkg.
`timescale 1ns / 1ps
module nkh_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input nkh_pkg::in_item_t in_data,
	output logic cmd_valid,
	input logic cmd_ready,
	output nkh_pkg::cmd_t cmd_data
);
	import nkh_pkg::*;
	logic [63:0] key_q;
	logic [63:0] sum;
	logic [63:0] next_key;
	logic accept;

	assign sum = key_q + {61'd0, sym_digit(in_data.symbol)};
	assign next_key = {sum[61:0], 2'b00} + sum;
	assign in_ready = !(in_data.last && !cmd_ready);
	assign accept = in_valid && in_ready;
	assign cmd_valid = in_valid && in_data.last;
	assign cmd_data = '{action: in_data.action, key: next_key};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (accept) begin
			key_q <= in_data.last ? 64'd0 : next_key;
		end
	end
endmodule

### hw/rtl/nkh_queue.sv
// Two-entry command queue between front and back.
// Depends on nkh_pkg.
`timescale 1ns / 1ps
module nkh_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input nkh_pkg::cmd_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output nkh_pkg::cmd_t rd_data
);
	import nkh_pkg::*;
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

### hw/rtl/nkh_back.sv
// Back part: splitmix64 over registered steps, then linear probe of the slot table.
// Depends on nkh_pkg; holds the slot key memory and the slot valid memory.
`timescale 1ns / 1ps
module nkh_back #(
	parameter int unsigned TABLE_SLOTS = nkh_pkg::TABLE_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [63:0] seed,
	input logic cmd_valid,
	output logic cmd_ready,
	input nkh_pkg::cmd_t cmd_data,
	output logic out_valid,
	input logic out_ready,
	output nkh_pkg::out_item_t out_data,
	output logic busy
);
	import nkh_pkg::*;
	localparam int unsigned AW = $clog2(TABLE_SLOTS);
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [3:0] MIX_DONE = 4'd10;

	back_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [63:0] v_q;
	logic [63:0] prod_q;
	logic [3:0] mstep_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] probes_q;
	logic valid_mem [TABLE_SLOTS];
	logic [63:0] slot_key_mem [TABLE_SLOTS];
	logic [63:0] rd_key_q;
	logic rd_valid_q;
	logic clr_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] home;
	logic [63:0] v_next;
	logic [63:0] prod_next;
	logic [63:0] mconst;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic hit, empty, exhausted, do_store;
	out_item_t verdict_q;
	out_item_t res_q;
	logic out_valid_q;

	// 64x64 product modulo 2^64 from three 32x32 partial products, one per step
	assign mconst = (mstep_q < 4'd5) ? MUL1 : MUL2;
	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		mul_a = v_q[31:0];
		mul_b = mconst[31:0];
		case (mstep_q)
			4'd3, 4'd7: mul_b = mconst[63:32];
			4'd4, 4'd8: mul_a = v_q[63:32];
			default: ;
		endcase
	end

	always_comb begin
		v_next = v_q;
		prod_next = prod_q;
		case (mstep_q)
			4'd0: v_next = v_q + GOLDEN;
			4'd1: v_next = v_q ^ (v_q >> 30);
			4'd2, 4'd6: prod_next = mul_p;
			4'd3, 4'd7: prod_next = prod_q + {mul_p[31:0], 32'd0};
			4'd4, 4'd8: v_next = prod_q + {mul_p[31:0], 32'd0};
			4'd5: v_next = v_q ^ (v_q >> 27);
			4'd9: v_next = v_q ^ (v_q >> 31);
			default: ;
		endcase
	end

	assign home = v_q[AW-1:0];

	assign hit = rd_valid_q && (rd_key_q == cmd_q.key);
	assign empty = !rd_valid_q;
	assign exhausted = probes_q == CW'(TABLE_SLOTS - 1);
	assign do_store = state_q == ST_CHECK && empty && cmd_q.action == ACT_INSERT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd_valid && !clr_q) state_d = ST_MIX;
			ST_MIX: if (mstep_q == MIX_DONE) state_d = ST_PROBE;
			ST_PROBE: state_d = ST_CHECK;
			ST_CHECK: if (hit || empty || exhausted) state_d = ST_DONE;
				else state_d = ST_PROBE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = state_q == ST_IDLE && !clr_q;
		busy = state_q != ST_IDLE;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PROBE) begin
			rd_key_q <= slot_key_mem[pos_q];
			rd_valid_q <= valid_mem[pos_q];
		end
		if (clr_q) begin
			valid_mem[clr_addr_q] <= 1'b0;
		end else if (do_store) begin
			valid_mem[pos_q] <= 1'b1;
			slot_key_mem[pos_q] <= cmd_q.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
			res_q <= '0;
			verdict_q <= '0;
			mstep_q <= '0;
			pos_q <= '0;
			probes_q <= '0;
			cmd_q <= '0;
			v_q <= '0;
			prod_q <= '0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(TABLE_SLOTS - 1)) clr_q <= 1'b0;
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				res_q <= verdict_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (cmd_valid && !clr_q) begin
					cmd_q <= cmd_data;
					v_q <= cmd_data.key + seed;
					mstep_q <= '0;
				end
				ST_MIX: begin
					v_q <= v_next;
					prod_q <= prod_next;
					mstep_q <= mstep_q + 4'd1;
					if (mstep_q == MIX_DONE) begin
						pos_q <= home;
						probes_q <= '0;
					end
				end
				ST_CHECK: begin
					verdict_q.found <= hit;
					verdict_q.table_full <= !hit && !empty && cmd_q.action == ACT_INSERT;
					if (!(hit || empty || exhausted)) begin
						pos_q <= (pos_q == AW'(TABLE_SLOTS - 1)) ? '0 : pos_q + AW'(1);
						probes_q <= probes_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = res_q;
endmodule

### hw/rtl/nucleotide_key_hash_set_core.sv
// Nucleotide key hash set core: one character per cycle at the front, hash and probe behind;
// a last character waits while the command queue is full.
// A command holds the back through its hash steps and each probed slot.
// Reset loads the seed (114514) and clears the key; the back then clears the slot valid bits
// one per cycle, all TABLE_SLOTS (1024 by default) of them, before it takes a command. TABLE_SLOTS: power of two.
// Depends on nkh_pkg, nkh_front, nkh_queue, nkh_back and the defines header.
`timescale 1ns / 1ps
`include "nucleotide_key_hash_set_core_defines.svh"
module nucleotide_key_hash_set_core #(
	parameter int unsigned TABLE_SLOTS = nkh_pkg::TABLE_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input nkh_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output nkh_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [63:0] cfg_data
);
	import nkh_pkg::*;
	logic [63:0] seed_q;
	logic f_valid, f_ready, b_valid, b_ready, busy;
	cmd_t f_data, b_data;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	nkh_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data));
	nkh_queue u_queue (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_data), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));
	nkh_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (.clk, .arst_n, .seed(seed_q),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
		.out_valid, .out_ready, .out_data, .busy);

	`NKH_ASSERT_IMPL(a_excl, clk, arst_n, out_valid, !(out_data.found && out_data.table_full), "both set")
	`NKH_ASSERT_IMPL(a_take, clk, arst_n, b_valid && b_ready, !busy, "taken while busy")
	`NKH_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "dropped")
endmodule
